FILE: rtl/core/kvt_pkg.sv
package kvt_pkg;

    // Port widths of the command and result beats.
    localparam int CMD_W        = 3;
    localparam int KEY_PORT_W   = 32;
    localparam int VALUE_PORT_W = 64;
    localparam int SLOT_W       = 8;
    localparam int COUNT_PORT_W = 9;

    // Configuration register file.
    localparam int                  CAP_W             = 9;
    localparam logic [CAP_W-1:0]    CAP_RESET         = 9'd256;
    localparam int                  APB_DATA_W        = 32;
    localparam int                  APB_ADDR_W        = 3;
    localparam logic [APB_ADDR_W-1:0] REG_CAPACITY_ADDR = 3'd0;

    // Default table geometry.
    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int DEFAULT_KEY_WIDTH   = 32;
    localparam int DEFAULT_VALUE_WIDTH = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_UPDATE = 3'd1,
        CMD_UPSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_LOOKUP = 3'd4,
        CMD_READ   = 3'd5
    } cmd_t;

    // Memory strobes from the sequencer. Both stores share the read and
    // write addresses; the key store and value store have their own writes.
    typedef struct packed {
        logic rd_en;
        logic key_wr_en;
        logic value_wr_en;
    } mem_ctl_t;

endpackage

FILE: rtl/core/kvt_ram.sv
module kvt_ram #(
    parameter int DEPTH  = kvt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int WIDTH  = kvt_pkg::DEFAULT_KEY_WIDTH,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/kvt_ctrl.sv
module kvt_ctrl #(
    parameter int TABLE_DEPTH = kvt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int KEY_WIDTH   = kvt_pkg::DEFAULT_KEY_WIDTH,
    parameter int VALUE_WIDTH = kvt_pkg::DEFAULT_VALUE_WIDTH,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [kvt_pkg::CAP_W-1:0]         cap_limit,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [kvt_pkg::CMD_W-1:0]         s_command,
    input  logic [kvt_pkg::KEY_PORT_W-1:0]    s_key_in,
    input  logic [kvt_pkg::VALUE_PORT_W-1:0]  s_value_in,
    input  logic [kvt_pkg::SLOT_W-1:0]        s_slot_index,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ok,
    output logic [kvt_pkg::KEY_PORT_W-1:0]    m_key_out,
    output logic [kvt_pkg::VALUE_PORT_W-1:0]  m_value_out,
    output logic [kvt_pkg::COUNT_PORT_W-1:0]  m_pair_count,

    output kvt_pkg::mem_ctl_t                 mem_ctl,
    output logic [IDX_W-1:0]                  rd_addr,
    output logic [IDX_W-1:0]                  wr_addr,
    output logic [KEY_WIDTH-1:0]              key_wr_data,
    output logic [VALUE_WIDTH-1:0]            value_wr_data,
    input  logic [KEY_WIDTH-1:0]              key_rd_data,
    input  logic [VALUE_WIDTH-1:0]            value_rd_data
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WIDE_W = (CNT_W > kvt_pkg::CAP_W) ? CNT_W : kvt_pkg::CAP_W;
    localparam int SCMP_W = (CNT_W > kvt_pkg::SLOT_W) ? CNT_W : kvt_pkg::SLOT_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_ACT   = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_MOVE  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                            state_reg, state_next;
    kvt_pkg::cmd_t                     cmd_reg, cmd_next;
    logic [KEY_WIDTH-1:0]              key_reg, key_next;
    logic [VALUE_WIDTH-1:0]            value_reg, value_next;
    logic [kvt_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [CNT_W-1:0]                  issue_reg, issue_next;
    logic                              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]                  cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]                  hit_reg, hit_next;
    logic                              found_reg, found_next;
    logic                              res_ok_reg, res_ok_next;
    logic [KEY_WIDTH-1:0]              res_key_reg, res_key_next;
    logic [VALUE_WIDTH-1:0]            res_value_reg, res_value_next;
    logic                              m_valid_reg, m_valid_next;
    logic                              m_ok_reg, m_ok_next;
    logic [kvt_pkg::KEY_PORT_W-1:0]    m_key_reg, m_key_next;
    logic [kvt_pkg::VALUE_PORT_W-1:0]  m_value_reg, m_value_next;
    logic [kvt_pkg::COUNT_PORT_W-1:0]  m_count_reg, m_count_next;

    logic full;
    logic slot_ok;
    logic key_match;

    assign full = (WIDE_W'(count_reg) >= WIDE_W'(cap_limit))
               || (WIDE_W'(count_reg) >= WIDE_W'(TABLE_DEPTH));
    assign slot_ok   = SCMP_W'(slot_reg) < SCMP_W'(count_reg);
    assign key_match = cmp_valid_reg && (key_rd_data == key_reg);

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_key_out    = m_key_reg;
    assign m_value_out  = m_value_reg;
    assign m_pair_count = m_count_reg;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        res_ok_next    = res_ok_reg;
        res_key_next   = res_key_reg;
        res_value_next = res_value_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_ok_next      = m_ok_reg;
        m_key_next     = m_key_reg;
        m_value_next   = m_value_reg;
        m_count_next   = m_count_reg;
        mem_ctl        = '0;
        rd_addr        = issue_reg[IDX_W-1:0];
        wr_addr        = count_reg[IDX_W-1:0];
        key_wr_data    = key_reg;
        value_wr_data  = value_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next       = kvt_pkg::cmd_t'(s_command);
                    key_next       = KEY_WIDTH'(s_key_in);
                    value_next     = VALUE_WIDTH'(s_value_in);
                    slot_next      = s_slot_index;
                    issue_next     = '0;
                    found_next     = 1'b0;
                    res_ok_next    = 1'b0;
                    res_key_next   = '0;
                    res_value_next = '0;
                    if (s_command == kvt_pkg::CMD_INSERT || s_command == kvt_pkg::CMD_UPDATE
                        || s_command == kvt_pkg::CMD_UPSERT || s_command == kvt_pkg::CMD_ERASE
                        || s_command == kvt_pkg::CMD_LOOKUP) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_ACT;
                    end
                end
            end

            // One read issued per cycle; the compare sees the key read in the cycle
            // before, so the first match in slot order stops the scan.
            ST_SCAN: begin
                priority if (key_match) begin
                    found_next = 1'b1;
                    hit_next   = cmp_idx_reg;
                    state_next = ST_ACT;
                end else if (issue_reg < count_reg) begin
                    mem_ctl.rd_en  = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end else begin
                    found_next = 1'b0;
                    state_next = ST_ACT;
                end
            end

            ST_ACT: begin
                state_next = ST_DONE;
                unique case (cmd_reg)
                    kvt_pkg::CMD_INSERT: begin
                        if (!found_reg && !full) begin
                            mem_ctl.key_wr_en   = 1'b1;
                            mem_ctl.value_wr_en = 1'b1;
                            count_next          = count_reg + CNT_W'(1);
                            res_ok_next         = 1'b1;
                        end
                    end
                    kvt_pkg::CMD_UPDATE: begin
                        if (found_reg) begin
                            mem_ctl.value_wr_en = 1'b1;
                            wr_addr             = hit_reg;
                            res_ok_next         = 1'b1;
                        end
                    end
                    kvt_pkg::CMD_UPSERT: begin
                        priority if (found_reg) begin
                            mem_ctl.value_wr_en = 1'b1;
                            wr_addr             = hit_reg;
                            res_ok_next         = 1'b1;
                        end else if (!full) begin
                            mem_ctl.key_wr_en   = 1'b1;
                            mem_ctl.value_wr_en = 1'b1;
                            count_next          = count_reg + CNT_W'(1);
                            res_ok_next         = 1'b1;
                        end else begin
                            res_ok_next = 1'b0;
                        end
                    end
                    kvt_pkg::CMD_ERASE: begin
                        if (found_reg) begin
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = IDX_W'(count_reg - CNT_W'(1));
                            state_next    = ST_MOVE;
                        end
                    end
                    kvt_pkg::CMD_LOOKUP: begin
                        if (found_reg) begin
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = hit_reg;
                            state_next    = ST_FETCH;
                        end
                    end
                    kvt_pkg::CMD_READ: begin
                        if (slot_ok) begin
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = IDX_W'(slot_reg);
                            state_next    = ST_FETCH;
                        end
                    end
                    default: begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end

            ST_FETCH: begin
                res_ok_next    = 1'b1;
                res_value_next = value_rd_data;
                if (cmd_reg == kvt_pkg::CMD_READ) begin
                    res_key_next = key_rd_data;
                end
                state_next = ST_DONE;
            end

            // The last pair overwrites the erased slot, which is harmless
            // when the erased slot is the last one.
            ST_MOVE: begin
                mem_ctl.key_wr_en   = 1'b1;
                mem_ctl.value_wr_en = 1'b1;
                wr_addr             = hit_reg;
                key_wr_data         = key_rd_data;
                value_wr_data       = value_rd_data;
                count_next          = count_reg - CNT_W'(1);
                res_ok_next         = 1'b1;
                state_next          = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_key_next   = kvt_pkg::KEY_PORT_W'(res_key_reg);
                    m_value_next = kvt_pkg::VALUE_PORT_W'(res_value_reg);
                    m_count_next = kvt_pkg::COUNT_PORT_W'(count_reg);
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        value_reg     <= value_next;
        slot_reg      <= slot_next;
        issue_reg     <= issue_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_reg       <= hit_next;
        found_reg     <= found_next;
        res_ok_reg    <= res_ok_next;
        res_key_reg   <= res_key_next;
        res_value_reg <= res_value_next;
        m_ok_reg      <= m_ok_next;
        m_key_reg     <= m_key_next;
        m_value_reg   <= m_value_next;
        m_count_reg   <= m_count_next;
    end

endmodule

FILE: rtl/core/bounded_key_value_table_top.sv
// A keyed command runs the one-entry-per-cycle key scan over the stored pairs (count, at
// most TABLE_DEPTH); a read-index command and an unknown command skip the scan. A new
// command is taken only once the previous one has placed its result beat.
// Reset (aresetn low, synchronous): the table is emptied, capacity_limit returns to 256,
// and the result valid flag is cleared. The key and value stores are not cleared.
module bounded_key_value_table_top #(
    parameter int TABLE_DEPTH = kvt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int KEY_WIDTH   = kvt_pkg::DEFAULT_KEY_WIDTH,
    parameter int VALUE_WIDTH = kvt_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kvt_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [kvt_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [kvt_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,

    // Command channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kvt_pkg::CMD_W-1:0]           s_command,
    input  logic [kvt_pkg::KEY_PORT_W-1:0]      s_key_in,
    input  logic [kvt_pkg::VALUE_PORT_W-1:0]    s_value_in,
    input  logic [kvt_pkg::SLOT_W-1:0]          s_slot_index,

    // Result channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_ok,
    output logic [kvt_pkg::KEY_PORT_W-1:0]      m_key_out,
    output logic [kvt_pkg::VALUE_PORT_W-1:0]    m_value_out,
    output logic [kvt_pkg::COUNT_PORT_W-1:0]    m_pair_count
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // The pairs live packed in slots 0 to count-1 of two memories with
    // registered reads. Every keyed command reads the key store from slot 0
    // upward, one read per cycle, and compares each key the cycle after its
    // read. The sequencer then writes back the new pair or value, reads the
    // value for a lookup, or for an erase reads the last pair and writes it
    // into the freed slot. The sequencer handles one command at a time, so
    // a write never overlaps a read of the same slot. The result beat sits
    // in its own register, so a new command is taken while it still waits.

    logic [kvt_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic                      cap_write;

    kvt_pkg::mem_ctl_t         mem_ctl;
    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W-1:0]          wr_addr;
    logic [KEY_WIDTH-1:0]      key_wr_data;
    logic [VALUE_WIDTH-1:0]    value_wr_data;
    logic [KEY_WIDTH-1:0]      key_rd_data;
    logic [VALUE_WIDTH-1:0]    value_rd_data;

    // The capacity register is written in the access phase of a write to
    // its address; writes to any other address are dropped.
    assign pready    = 1'b1;
    assign cap_write = psel && penable && pwrite && (paddr == kvt_pkg::REG_CAPACITY_ADDR);
    assign cap_next  = cap_write ? pwdata[kvt_pkg::CAP_W-1:0] : cap_reg;
    assign prdata    = (paddr == kvt_pkg::REG_CAPACITY_ADDR)
                     ? kvt_pkg::APB_DATA_W'(cap_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= kvt_pkg::CAP_RESET;
        end else begin
            cap_reg <= cap_next;
        end
    end

    kvt_ram #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (KEY_WIDTH),
        .ADDR_W (IDX_W)
    ) u_key_store (
        .aclk    (aclk),
        .wr_en   (mem_ctl.key_wr_en),
        .wr_addr (wr_addr),
        .wr_data (key_wr_data),
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (key_rd_data)
    );

    kvt_ram #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (VALUE_WIDTH),
        .ADDR_W (IDX_W)
    ) u_value_store (
        .aclk    (aclk),
        .wr_en   (mem_ctl.value_wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_wr_data),
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (value_rd_data)
    );

    kvt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cap_limit     (cap_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_key_in      (s_key_in),
        .s_value_in    (s_value_in),
        .s_slot_index  (s_slot_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_key_out     (m_key_out),
        .m_value_out   (m_value_out),
        .m_pair_count  (m_pair_count),
        .mem_ctl       (mem_ctl),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .key_wr_data   (key_wr_data),
        .value_wr_data (value_wr_data),
        .key_rd_data   (key_rd_data),
        .value_rd_data (value_rd_data)
    );

endmodule
